// ----- hw/rtl/spc_pkg.sv -----
// Shared types, widths and shape decoding for the shape pair collision test.
`timescale 1ns / 1ps

package spc_pkg;

    localparam int FIELD_BITS = 16;
    localparam int COORD_BITS = 16;
    localparam int EXT_BITS   = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

    localparam int SW  = FIELD_BITS + 2;   // doubled coordinate, signed
    localparam int DW  = SW + 1;           // difference of two coordinates
    localparam int PW  = 2 * DW;           // product of two differences
    localparam int QW  = PW + 1;           // sum or difference of two products
    localparam int RW  = 2 * FIELD_BITS;   // squared radius
    localparam int HW  = FIELD_BITS + 2;   // half of a split wide operand
    localparam int CAW = 2 * HW;           // cross term magnitude, segment length squared
    localparam int LW  = 2 * CAW + 1;      // wide product sums

    typedef enum logic [1:0] {
        KIND_CIRCLE = 2'd0,
        KIND_RECT   = 2'd1,
        KIND_SEG    = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef logic signed [SW-1:0] coord_t;

    typedef struct packed {
        kind_t  kind;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } shape_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        kind_t p;
        kind_t q;
    } kind_pair_t;

    // per-stage load enables for the crossing units
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

    function automatic coord_t sext(input logic [FIELD_BITS-1:0] f);
        logic signed [FIELD_BITS-1:0] v;
        v = signed'(f << (FIELD_BITS - EXT_BITS)) >>> (FIELD_BITS - EXT_BITS);
        return coord_t'(v);
    endfunction

    // Double all coordinates but rectangle sizes; clamp negative sizes to zero.
    function automatic shape_t load(input logic [1:0] k,
                                    input logic [FIELD_BITS-1:0] f0,
                                    input logic [FIELD_BITS-1:0] f1,
                                    input logic [FIELD_BITS-1:0] f2,
                                    input logic [FIELD_BITS-1:0] f3);
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        shape_t s;
        x0 = sext(f0);
        y0 = sext(f1);
        x1 = sext(f2);
        y1 = sext(f3);
        s.kind = kind_t'(k);
        s.x0   = x0 <<< 1;
        s.y0   = y0 <<< 1;
        unique case (s.kind)
            KIND_CIRCLE:
            begin
                s.x1 = (x1 < 0) ? '0 : (x1 <<< 1);
                s.y1 = '0;
            end
            KIND_RECT:
            begin
                s.x1 = (x1 < 0) ? '0 : x1;
                s.y1 = (y1 < 0) ? '0 : y1;
            end
            KIND_SEG, KIND_NONE:
            begin
                s.x1 = x1 <<< 1;
                s.y1 = y1 <<< 1;
            end
        endcase
        return s;
    endfunction

endpackage

// ----- hw/rtl/spc_if.sv -----
// Handshake channels for shape pairs and collision results.
`timescale 1ns / 1ps

interface spc_pair_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         kind_a;
    logic signed [spc_pkg::FIELD_BITS-1:0] a_x0;
    logic signed [spc_pkg::FIELD_BITS-1:0] a_y0;
    logic signed [spc_pkg::FIELD_BITS-1:0] a_x1;
    logic signed [spc_pkg::FIELD_BITS-1:0] a_y1;
    logic [1:0]                         kind_b;
    logic signed [spc_pkg::FIELD_BITS-1:0] b_x0;
    logic signed [spc_pkg::FIELD_BITS-1:0] b_y0;
    logic signed [spc_pkg::FIELD_BITS-1:0] b_x1;
    logic signed [spc_pkg::FIELD_BITS-1:0] b_y1;

    modport source (output valid, kind_a, a_x0, a_y0, a_x1, a_y1,
                    kind_b, b_x0, b_y0, b_x1, b_y1, input ready);
    modport sink (input valid, kind_a, a_x0, a_y0, a_x1, a_y1,
                  kind_b, b_x0, b_y0, b_x1, b_y1, output ready);
endinterface

interface spc_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

// ----- hw/rtl/shape_pair_collision_test.sv -----
// Top level: eight-stage pipelined collision test of two 2D shapes.
//
// Usage:
//   pair   - valid/ready channel carrying two shapes (kind, two coordinate pairs
//            each). A word is taken at a rising edge with valid and ready high.
//   result - valid/ready channel carrying one hit bit for every pair taken,
//            in the order the pairs arrived.
//   Throughput: one pair per cycle while no stall holds the pipeline; the
//   eight-stage datapath (squares, wide split products for the circle-segment
//   perpendicular test, four crossing units for rectangle edges) holds up to
//   eight pairs in flight.
//   Stall: when result.ready is low the output stage holds its word; earlier
//   stages keep filling empty slots, so pair.ready drops only once every
//   stage is full. No word is lost or repeated.
//   Reset: rst_n low empties the pipeline at once; pair.ready is high again
//   right after reset is released.
`timescale 1ns / 1ps

module shape_pair_collision_test
(
    input  logic       clk,
    input  logic       rst_n,
    spc_pair_if.sink   pair,
    spc_hit_if.source  result
);

    localparam int NS = 8;

    logic [NS:1]         v_reg;
    logic [NS+1:1]       en;
    spc_pkg::kind_pair_t kp_reg [NS-1:1];

    // stage 1: decoded shapes, ordered so p has the lower kind
    spc_pkg::shape_t sa, sb;
    spc_pkg::shape_t p_reg, q_reg;
    logic            swap;

    // stage 2
    logic signed [spc_pkg::DW-1:0] ddx_next, ddy_next;
    logic signed [spc_pkg::DW-1:0] ddx_s2_reg, ddy_s2_reg, adx_s2_reg, ady_s2_reg;
    logic signed [spc_pkg::DW-1:0] sumx_s2_reg, sumy_s2_reg, hhr_s2_reg;
    logic signed [spc_pkg::DW-1:0] sdx_s2_reg, sdy_s2_reg, ux_s2_reg, uy_s2_reg;
    spc_pkg::coord_t               rad_s2_reg, hw_s2_reg, hh_s2_reg;

    // stage 3
    logic signed [spc_pkg::DW-1:0] ex_s3_reg, ey_s3_reg;
    logic signed [spc_pkg::PW-1:0] sqx_s3_reg, sqy_s3_reg, rs2_s3_reg, rad2_s3_reg;
    logic signed [spc_pkg::PW-1:0] sdx2_s3_reg, sdy2_s3_reg, tx_s3_reg, ty_s3_reg;
    logic signed [spc_pkg::PW-1:0] cx_s3_reg, cy_s3_reg, ux2_s3_reg, uy2_s3_reg;
    logic                          rej_s3_reg, cin_s3_reg, rr_s3_reg;

    // stage 4
    logic signed [spc_pkg::PW-1:0] exsq_s4_reg, eysq_s4_reg;
    logic signed [spc_pkg::QW-1:0] t_s4_reg, crv_s4_reg;
    logic [spc_pkg::CAW-1:0]       len2_s4_reg;
    logic [spc_pkg::RW-1:0]        r2_s4_reg;
    logic                          cc_s4_reg, wle_s4_reg, ule_s4_reg;
    logic                          rej_s4_reg, cin_s4_reg, rr_s4_reg;

    // stage 5
    logic [spc_pkg::CAW-1:0]       cabs_s5_reg, len2_s5_reg;
    logic [spc_pkg::RW-1:0]        r2_s5_reg;
    logic                          near_s5_reg, far_s5_reg, wle_s5_reg, ule_s5_reg;
    logic                          cc_s5_reg, rr_s5_reg, cr_s5_reg;

    // stage 6
    logic [2*spc_pkg::HW-1:0]            chh_s6_reg, chl_s6_reg, cll_s6_reg;
    logic [spc_pkg::RW+spc_pkg::HW-1:0]  rlh_s6_reg, rll_s6_reg;
    logic                                near_s6_reg, far_s6_reg, wle_s6_reg, ule_s6_reg;
    logic                                cc_s6_reg, rr_s6_reg, cr_s6_reg, ss_s6_reg, rs_s6_reg;

    // stage 7
    logic [spc_pkg::LW-1:0] lhs_s7_reg, rhs_s7_reg;
    logic                   near_s7_reg, far_s7_reg, wle_s7_reg, ule_s7_reg;
    logic                   cc_s7_reg, rr_s7_reg, cr_s7_reg, ss_s7_reg, rs_s7_reg;

    // stage 8: output word
    logic hit_reg;
    logic hit_next;
    logic cs_hit;

    // crossing units
    spc_pkg::point_t   pt_lt, pt_rt, pt_lb, pt_rb, pt_q0, pt_q1, pt_p0, pt_p1;
    spc_pkg::point_t   u0_a, u0_b;
    spc_pkg::stage_en_t uen;
    logic [3:0]        xhit;

    // ---------------- flow control ----------------
    always_comb
    begin
        en[NS+1] = result.ready;
        for (int k = NS; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign pair.ready   = en[1];
    assign result.valid = v_reg[NS];
    assign result.hit   = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= pair.valid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 1 ----------------
    always_comb
    begin
        sa   = spc_pkg::load(pair.kind_a, pair.a_x0, pair.a_y0, pair.a_x1, pair.a_y1);
        sb   = spc_pkg::load(pair.kind_b, pair.b_x0, pair.b_y0, pair.b_x1, pair.b_y1);
        swap = sa.kind > sb.kind;
    end

    // ---------------- crossing unit inputs ----------------
    always_comb
    begin
        pt_lt = '{x: p_reg.x0 - p_reg.x1, y: p_reg.y0 - p_reg.y1};
        pt_rt = '{x: p_reg.x0 + p_reg.x1, y: p_reg.y0 - p_reg.y1};
        pt_lb = '{x: p_reg.x0 - p_reg.x1, y: p_reg.y0 + p_reg.y1};
        pt_rb = '{x: p_reg.x0 + p_reg.x1, y: p_reg.y0 + p_reg.y1};
        pt_p0 = '{x: p_reg.x0, y: p_reg.y0};
        pt_p1 = '{x: p_reg.x1, y: p_reg.y1};
        pt_q0 = '{x: q_reg.x0, y: q_reg.y0};
        pt_q1 = '{x: q_reg.x1, y: q_reg.y1};
        // unit 0 serves segment-segment, or the top edge of a rectangle
        u0_a  = (p_reg.kind == spc_pkg::KIND_SEG) ? pt_p0 : pt_lt;
        u0_b  = (p_reg.kind == spc_pkg::KIND_SEG) ? pt_p1 : pt_rt;
        uen   = '{s2: en[2], s3: en[3], s4: en[4], s5: en[5]};
    end

    spc_cross u_cross0 (.clk(clk), .en(uen), .a(u0_a),  .b(u0_b),  .c(pt_q0), .d(pt_q1),
                        .hit(xhit[0]));
    spc_cross u_cross1 (.clk(clk), .en(uen), .a(pt_lt), .b(pt_lb), .c(pt_q0), .d(pt_q1),
                        .hit(xhit[1]));
    spc_cross u_cross2 (.clk(clk), .en(uen), .a(pt_rt), .b(pt_rb), .c(pt_q0), .d(pt_q1),
                        .hit(xhit[2]));
    spc_cross u_cross3 (.clk(clk), .en(uen), .a(pt_lb), .b(pt_rb), .c(pt_q0), .d(pt_q1),
                        .hit(xhit[3]));

    // ---------------- stage 2 differences ----------------
    always_comb
    begin
        ddx_next = spc_pkg::DW'(p_reg.x0) - spc_pkg::DW'(q_reg.x0);
        ddy_next = spc_pkg::DW'(p_reg.y0) - spc_pkg::DW'(q_reg.y0);
    end

    // ---------------- circle-segment decision ----------------
    always_comb
    begin
        if (near_s7_reg)
        begin
            cs_hit = wle_s7_reg;
        end
        else if (far_s7_reg)
        begin
            cs_hit = ule_s7_reg;
        end
        else
        begin
            cs_hit = lhs_s7_reg <= rhs_s7_reg;
        end
    end

    always_comb
    begin
        priority if (kp_reg[7].q == spc_pkg::KIND_NONE)
        begin
            hit_next = 1'b0;
        end
        else if (kp_reg[7].p == spc_pkg::KIND_CIRCLE && kp_reg[7].q == spc_pkg::KIND_CIRCLE)
        begin
            hit_next = cc_s7_reg;
        end
        else if (kp_reg[7].p == spc_pkg::KIND_RECT && kp_reg[7].q == spc_pkg::KIND_RECT)
        begin
            hit_next = rr_s7_reg;
        end
        else if (kp_reg[7].p == spc_pkg::KIND_SEG)
        begin
            hit_next = ss_s7_reg;
        end
        else if (kp_reg[7].p == spc_pkg::KIND_CIRCLE && kp_reg[7].q == spc_pkg::KIND_RECT)
        begin
            hit_next = cr_s7_reg;
        end
        else if (kp_reg[7].p == spc_pkg::KIND_CIRCLE)
        begin
            hit_next = cs_hit;
        end
        else
        begin
            hit_next = rs_s7_reg;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p_reg     <= swap ? sb : sa;
            q_reg     <= swap ? sa : sb;
            kp_reg[1] <= swap ? spc_pkg::kind_pair_t'{p: sb.kind, q: sa.kind} :
                                spc_pkg::kind_pair_t'{p: sa.kind, q: sb.kind};
        end
        for (int k = 2; k <= NS - 1; k++)
        begin
            if (en[k])
            begin
                kp_reg[k] <= kp_reg[k-1];
            end
        end

        if (en[2])
        begin
            ddx_s2_reg  <= ddx_next;
            ddy_s2_reg  <= ddy_next;
            adx_s2_reg  <= (ddx_next < 0) ? -ddx_next : ddx_next;
            ady_s2_reg  <= (ddy_next < 0) ? -ddy_next : ddy_next;
            sumx_s2_reg <= spc_pkg::DW'(p_reg.x1) + spc_pkg::DW'(q_reg.x1);
            sumy_s2_reg <= spc_pkg::DW'(p_reg.y1) + spc_pkg::DW'(q_reg.y1);
            hhr_s2_reg  <= spc_pkg::DW'(q_reg.y1) + spc_pkg::DW'(p_reg.x1);
            sdx_s2_reg  <= spc_pkg::DW'(q_reg.x1) - spc_pkg::DW'(q_reg.x0);
            sdy_s2_reg  <= spc_pkg::DW'(q_reg.y1) - spc_pkg::DW'(q_reg.y0);
            ux_s2_reg   <= spc_pkg::DW'(p_reg.x0) - spc_pkg::DW'(q_reg.x1);
            uy_s2_reg   <= spc_pkg::DW'(p_reg.y0) - spc_pkg::DW'(q_reg.y1);
            rad_s2_reg  <= p_reg.x1;
            hw_s2_reg   <= q_reg.x1;
            hh_s2_reg   <= q_reg.y1;
        end

        if (en[3])
        begin
            ex_s3_reg   <= adx_s2_reg - spc_pkg::DW'(hw_s2_reg);
            ey_s3_reg   <= ady_s2_reg - spc_pkg::DW'(hh_s2_reg);
            sqx_s3_reg  <= ddx_s2_reg * ddx_s2_reg;
            sqy_s3_reg  <= ddy_s2_reg * ddy_s2_reg;
            rs2_s3_reg  <= sumx_s2_reg * sumx_s2_reg;
            rad2_s3_reg <= rad_s2_reg * rad_s2_reg;
            sdx2_s3_reg <= sdx_s2_reg * sdx_s2_reg;
            sdy2_s3_reg <= sdy_s2_reg * sdy_s2_reg;
            tx_s3_reg   <= ddx_s2_reg * sdx_s2_reg;
            ty_s3_reg   <= ddy_s2_reg * sdy_s2_reg;
            cx_s3_reg   <= ddx_s2_reg * sdy_s2_reg;
            cy_s3_reg   <= ddy_s2_reg * sdx_s2_reg;
            ux2_s3_reg  <= ux_s2_reg * ux_s2_reg;
            uy2_s3_reg  <= uy_s2_reg * uy_s2_reg;
            // circle-rectangle: clear miss on an axis, or center within a half size
            rej_s3_reg  <= (sumx_s2_reg <= adx_s2_reg) || (hhr_s2_reg <= ady_s2_reg);
            cin_s3_reg  <= (adx_s2_reg <= spc_pkg::DW'(hw_s2_reg)) ||
                           (ady_s2_reg <= spc_pkg::DW'(hh_s2_reg));
            rr_s3_reg   <= (adx_s2_reg <= sumx_s2_reg) && (ady_s2_reg <= sumy_s2_reg);
        end

        if (en[4])
        begin
            exsq_s4_reg <= ex_s3_reg * ex_s3_reg;
            eysq_s4_reg <= ey_s3_reg * ey_s3_reg;
            cc_s4_reg   <= (spc_pkg::QW'(sqx_s3_reg) + spc_pkg::QW'(sqy_s3_reg)) <=
                           spc_pkg::QW'(rs2_s3_reg);
            len2_s4_reg <= spc_pkg::CAW'(spc_pkg::QW'(sdx2_s3_reg) + spc_pkg::QW'(sdy2_s3_reg));
            t_s4_reg    <= spc_pkg::QW'(tx_s3_reg) + spc_pkg::QW'(ty_s3_reg);
            crv_s4_reg  <= spc_pkg::QW'(cx_s3_reg) - spc_pkg::QW'(cy_s3_reg);
            wle_s4_reg  <= (spc_pkg::QW'(sqx_s3_reg) + spc_pkg::QW'(sqy_s3_reg)) <=
                           spc_pkg::QW'(rad2_s3_reg);
            ule_s4_reg  <= (spc_pkg::QW'(ux2_s3_reg) + spc_pkg::QW'(uy2_s3_reg)) <=
                           spc_pkg::QW'(rad2_s3_reg);
            r2_s4_reg   <= spc_pkg::RW'(rad2_s3_reg);
            rej_s4_reg  <= rej_s3_reg;
            cin_s4_reg  <= cin_s3_reg;
            rr_s4_reg   <= rr_s3_reg;
        end

        if (en[5])
        begin
            cabs_s5_reg <= spc_pkg::CAW'((crv_s4_reg < 0) ? -crv_s4_reg : crv_s4_reg);
            len2_s5_reg <= len2_s4_reg;
            r2_s5_reg   <= r2_s4_reg;
            near_s5_reg <= (len2_s4_reg == '0) || (t_s4_reg < 0);
            far_s5_reg  <= t_s4_reg > signed'(spc_pkg::QW'(len2_s4_reg));
            wle_s5_reg  <= wle_s4_reg;
            ule_s5_reg  <= ule_s4_reg;
            cc_s5_reg   <= cc_s4_reg;
            rr_s5_reg   <= rr_s4_reg;
            // corner test is strict
            cr_s5_reg   <= !rej_s4_reg && (cin_s4_reg ||
                           ((spc_pkg::QW'(exsq_s4_reg) + spc_pkg::QW'(eysq_s4_reg)) <
                            signed'(spc_pkg::QW'(r2_s4_reg))));
        end

        if (en[6])
        begin
            // split the wide operands to keep each multiply narrow
            chh_s6_reg  <= cabs_s5_reg[spc_pkg::CAW-1:spc_pkg::HW] *
                           cabs_s5_reg[spc_pkg::CAW-1:spc_pkg::HW];
            chl_s6_reg  <= cabs_s5_reg[spc_pkg::CAW-1:spc_pkg::HW] *
                           cabs_s5_reg[spc_pkg::HW-1:0];
            cll_s6_reg  <= cabs_s5_reg[spc_pkg::HW-1:0] * cabs_s5_reg[spc_pkg::HW-1:0];
            rlh_s6_reg  <= r2_s5_reg * len2_s5_reg[spc_pkg::CAW-1:spc_pkg::HW];
            rll_s6_reg  <= r2_s5_reg * len2_s5_reg[spc_pkg::HW-1:0];
            near_s6_reg <= near_s5_reg;
            far_s6_reg  <= far_s5_reg;
            wle_s6_reg  <= wle_s5_reg;
            ule_s6_reg  <= ule_s5_reg;
            cc_s6_reg   <= cc_s5_reg;
            rr_s6_reg   <= rr_s5_reg;
            cr_s6_reg   <= cr_s5_reg;
            ss_s6_reg   <= xhit[0];
            rs_s6_reg   <= |xhit;
        end

        if (en[7])
        begin
            lhs_s7_reg  <= (spc_pkg::LW'(chh_s6_reg) << (2 * spc_pkg::HW)) +
                           (spc_pkg::LW'(chl_s6_reg) << (spc_pkg::HW + 1)) +
                           spc_pkg::LW'(cll_s6_reg);
            rhs_s7_reg  <= (spc_pkg::LW'(rlh_s6_reg) << spc_pkg::HW) +
                           spc_pkg::LW'(rll_s6_reg);
            near_s7_reg <= near_s6_reg;
            far_s7_reg  <= far_s6_reg;
            wle_s7_reg  <= wle_s6_reg;
            ule_s7_reg  <= ule_s6_reg;
            cc_s7_reg   <= cc_s6_reg;
            rr_s7_reg   <= rr_s6_reg;
            cr_s7_reg   <= cr_s6_reg;
            ss_s7_reg   <= ss_s6_reg;
            rs_s7_reg   <= rs_s6_reg;
        end

        if (en[8])
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

// ----- hw/rtl/spc_cross.sv -----
// Pipelined strict interior crossing test of two segments (four stages).
`timescale 1ns / 1ps

module spc_cross
(
    input  logic                clk,
    input  spc_pkg::stage_en_t  en,
    input  spc_pkg::point_t     a,
    input  spc_pkg::point_t     b,
    input  spc_pkg::point_t     c,
    input  spc_pkg::point_t     d,
    output logic                hit
);

    logic signed [spc_pkg::DW-1:0] e1_reg, e2_reg, f1_reg, f2_reg, g1_reg, g2_reg;
    logic signed [spc_pkg::PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [spc_pkg::QW-1:0] den_reg, un_reg, vn_reg;
    logic                          hit_reg;
    logic                          hit_next;

    always_comb
    begin
        if (den_reg > 0)
        begin
            hit_next = (un_reg > 0) && (un_reg < den_reg) &&
                       (vn_reg > 0) && (vn_reg < den_reg);
        end
        else if (den_reg < 0)
        begin
            // negative denominator: mirror the bounds
            hit_next = (un_reg < 0) && (un_reg > den_reg) &&
                       (vn_reg < 0) && (vn_reg > den_reg);
        end
        else
        begin
            hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            e1_reg <= spc_pkg::DW'(b.x) - spc_pkg::DW'(a.x);
            e2_reg <= spc_pkg::DW'(b.y) - spc_pkg::DW'(a.y);
            f1_reg <= spc_pkg::DW'(d.x) - spc_pkg::DW'(c.x);
            f2_reg <= spc_pkg::DW'(d.y) - spc_pkg::DW'(c.y);
            g1_reg <= spc_pkg::DW'(a.y) - spc_pkg::DW'(c.y);
            g2_reg <= spc_pkg::DW'(a.x) - spc_pkg::DW'(c.x);
        end
        if (en.s3)
        begin
            p1_reg <= e1_reg * f2_reg;
            p2_reg <= f1_reg * e2_reg;
            p3_reg <= f1_reg * g1_reg;
            p4_reg <= f2_reg * g2_reg;
            p5_reg <= e1_reg * g1_reg;
            p6_reg <= e2_reg * g2_reg;
        end
        if (en.s4)
        begin
            den_reg <= spc_pkg::QW'(p1_reg) - spc_pkg::QW'(p2_reg);
            un_reg  <= spc_pkg::QW'(p3_reg) - spc_pkg::QW'(p4_reg);
            vn_reg  <= spc_pkg::QW'(p5_reg) - spc_pkg::QW'(p6_reg);
        end
        if (en.s5)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ----- dv/shape_pair_collision_test_tb.sv -----
// Self-checking testbench for the shape pair collision test: directed table, then random pairs.
`timescale 1ns / 1ps

module shape_pair_collision_test_tb;

    typedef spc_pkg::kind_t kind_t;

    localparam kind_t KIND_CIRCLE = spc_pkg::KIND_CIRCLE;
    localparam kind_t KIND_RECT   = spc_pkg::KIND_RECT;
    localparam kind_t KIND_SEG    = spc_pkg::KIND_SEG;
    localparam kind_t KIND_NONE   = spc_pkg::KIND_NONE;

    typedef logic signed [15:0] fld_t;
    typedef logic signed [63:0] wide_t;

    typedef struct {
        kind_t ka;
        fld_t  ax0, ay0, ax1, ay1;
        kind_t kb;
        fld_t  bx0, by0, bx1, by1;
    } pair_word_t;

    typedef struct {
        pair_word_t p;
        int         want;   // -1: use the predictor
    } table_row_t;

    typedef struct {
        kind_t k;
        wide_t x0, y0, x1, y1;
    } geom_t;

    logic clk;
    logic rst_n;

    spc_pair_if pair ();
    spc_hit_if  result ();

    shape_pair_collision_test dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair.sink),
        .result (result.source)
    );

    bit         hit_queue[$];
    int         fail_count;
    int         sent_count;
    int         got_count;
    int         hit_count;
    int         idle_cycles;
    table_row_t dir_table[$];

    localparam int WATCHDOG_LIMIT = 5000;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic wide_t mag(input wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic geom_t to_geom(input kind_t k, input fld_t x0, input fld_t y0,
                                      input fld_t x1, input fld_t y1);
        geom_t g;
        g.k  = k;
        g.x0 = 2 * wide_t'(x0);
        g.y0 = 2 * wide_t'(y0);
        if (k == KIND_CIRCLE)
        begin
            g.x1 = (x1 < 0) ? 0 : 2 * wide_t'(x1);
            g.y1 = 0;
        end
        else if (k == KIND_RECT)
        begin
            g.x1 = (x1 < 0) ? 0 : wide_t'(x1);
            g.y1 = (y1 < 0) ? 0 : wide_t'(y1);
        end
        else
        begin
            g.x1 = 2 * wide_t'(x1);
            g.y1 = 2 * wide_t'(y1);
        end
        return g;
    endfunction

    function automatic bit strict_cross(input wide_t ax, input wide_t ay, input wide_t bx,
                                        input wide_t by, input wide_t cx, input wide_t cy,
                                        input wide_t dx, input wide_t dy);
        wide_t den;
        wide_t un;
        wide_t vn;
        den = (bx - ax) * (dy - cy) - (dx - cx) * (by - ay);
        un  = (dx - cx) * (ay - cy) - (dy - cy) * (ax - cx);
        vn  = (bx - ax) * (ay - cy) - (by - ay) * (ax - cx);
        if (den == 0)
            return 1'b0;
        if (den < 0)
        begin
            den = -den;
            un  = -un;
            vn  = -vn;
        end
        return un > 0 && un < den && vn > 0 && vn < den;
    endfunction

    function automatic bit circle_rect(input geom_t c, input geom_t r);
        wide_t dx;
        wide_t dy;
        wide_t ex;
        wide_t ey;
        dx = mag(c.x0 - r.x0);
        dy = mag(c.y0 - r.y0);
        if (r.x1 + c.x1 <= dx || r.y1 + c.x1 <= dy)
            return 1'b0;
        if (dx <= r.x1 || dy <= r.y1)
            return 1'b1;
        ex = dx - r.x1;
        ey = dy - r.y1;
        return ex * ex + ey * ey < c.x1 * c.x1;
    endfunction

    function automatic bit circle_seg(input geom_t c, input geom_t s);
        wide_t dx;
        wide_t dy;
        wide_t wx;
        wide_t wy;
        wide_t len2;
        wide_t t;
        wide_t r2;
        wide_t cr;
        logic [127:0] lhs;
        logic [127:0] rhs;
        dx   = s.x1 - s.x0;
        dy   = s.y1 - s.y0;
        wx   = c.x0 - s.x0;
        wy   = c.y0 - s.y0;
        len2 = dx * dx + dy * dy;
        t    = wx * dx + wy * dy;
        r2   = c.x1 * c.x1;
        if (len2 == 0 || t < 0)
            return wx * wx + wy * wy <= r2;
        if (t > len2)
            return (c.x0 - s.x1) * (c.x0 - s.x1) + (c.y0 - s.y1) * (c.y0 - s.y1) <= r2;
        cr  = mag(wx * dy - wy * dx);
        lhs = 128'(cr) * 128'(cr);
        rhs = 128'(r2) * 128'(len2);
        return lhs <= rhs;
    endfunction

    function automatic bit rect_seg(input geom_t r, input geom_t s);
        wide_t l;
        wide_t rr;
        wide_t t;
        wide_t b;
        l  = r.x0 - r.x1;
        rr = r.x0 + r.x1;
        t  = r.y0 - r.y1;
        b  = r.y0 + r.y1;
        return strict_cross(l, t, rr, t, s.x0, s.y0, s.x1, s.y1) ||
               strict_cross(l, t, l, b, s.x0, s.y0, s.x1, s.y1) ||
               strict_cross(rr, t, rr, b, s.x0, s.y0, s.x1, s.y1) ||
               strict_cross(l, b, rr, b, s.x0, s.y0, s.x1, s.y1);
    endfunction

    function automatic bit predict_hit(input pair_word_t p);
        geom_t a;
        geom_t b;
        wide_t rs;
        a = to_geom(p.ka, p.ax0, p.ay0, p.ax1, p.ay1);
        b = to_geom(p.kb, p.bx0, p.by0, p.bx1, p.by1);
        if (a.k == KIND_NONE || b.k == KIND_NONE)
            return 1'b0;
        if (a.k == KIND_CIRCLE && b.k == KIND_CIRCLE)
        begin
            rs = a.x1 + b.x1;
            return (a.x0 - b.x0) * (a.x0 - b.x0) + (a.y0 - b.y0) * (a.y0 - b.y0) <= rs * rs;
        end
        if (a.k == KIND_RECT && b.k == KIND_RECT)
            return mag(a.x0 - b.x0) <= a.x1 + b.x1 && mag(a.y0 - b.y0) <= a.y1 + b.y1;
        if (a.k == KIND_SEG && b.k == KIND_SEG)
            return strict_cross(a.x0, a.y0, a.x1, a.y1, b.x0, b.y0, b.x1, b.y1);
        if (a.k == KIND_CIRCLE && b.k == KIND_RECT)
            return circle_rect(a, b);
        if (a.k == KIND_RECT && b.k == KIND_CIRCLE)
            return circle_rect(b, a);
        if (a.k == KIND_CIRCLE && b.k == KIND_SEG)
            return circle_seg(a, b);
        if (a.k == KIND_SEG && b.k == KIND_CIRCLE)
            return circle_seg(b, a);
        if (a.k == KIND_RECT && b.k == KIND_SEG)
            return rect_seg(a, b);
        return rect_seg(b, a);
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic fld_t rand_coord(input int span);
        if (span == 0)
            return fld_t'($urandom);
        return fld_t'($urandom_range(2 * span) - span);
    endfunction

    function automatic pair_word_t rand_pair();
        pair_word_t p;
        int         span;
        // keep most shapes near each other so hits are common
        case ($urandom_range(9))
            0, 1: span = 0;
            2: span = 4000;
            default: span = 60;
        endcase
        p.ka  = kind_t'($urandom_range(9) == 0 ? 3 : $urandom_range(2));
        p.kb  = kind_t'($urandom_range(9) == 0 ? 3 : $urandom_range(2));
        p.ax0 = rand_coord(span);
        p.ay0 = rand_coord(span);
        p.ax1 = rand_coord(span);
        p.ay1 = rand_coord(span);
        p.bx0 = rand_coord(span);
        p.by0 = rand_coord(span);
        p.bx1 = rand_coord(span);
        p.by1 = rand_coord(span);
        return p;
    endfunction

    function automatic pair_word_t mk(input kind_t ka, input int ax0, input int ay0,
                                      input int ax1, input int ay1, input kind_t kb,
                                      input int bx0, input int by0, input int bx1,
                                      input int by1);
        pair_word_t p;
        p.ka = ka; p.ax0 = fld_t'(ax0); p.ay0 = fld_t'(ay0);
        p.ax1 = fld_t'(ax1); p.ay1 = fld_t'(ay1);
        p.kb = kb; p.bx0 = fld_t'(bx0); p.by0 = fld_t'(by0);
        p.bx1 = fld_t'(bx1); p.by1 = fld_t'(by1);
        return p;
    endfunction

    task automatic add_row(input pair_word_t p, input int want);
        table_row_t r;
        r.p    = p;
        r.want = want;
        dir_table.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        fail_count++;
    endtask

    task automatic send_pair(input pair_word_t p, input int want);
        bit exp_hit;
        // random gap before the word, mostly short
        int gap;
        gap = ($urandom_range(3) == 0) ? (($urandom_range(15) == 0) ?
              $urandom_range(30, 8) : $urandom_range(2)) : 0;
        // drop valid only across a gap; back to back words keep it high
        if (gap > 0)
        begin
            pair.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        exp_hit = predict_hit(p);
        if (want >= 0 && want != int'(exp_hit))
            report_mismatch("table vs predictor", want, exp_hit);
        pair.valid  <= 1'b1;
        pair.kind_a <= p.ka;
        pair.a_x0   <= p.ax0;
        pair.a_y0   <= p.ay0;
        pair.a_x1   <= p.ax1;
        pair.a_y1   <= p.ay1;
        pair.kind_b <= p.kb;
        pair.b_x0   <= p.bx0;
        pair.b_y0   <= p.by0;
        pair.b_x1   <= p.bx1;
        pair.b_y1   <= p.by1;
        @(posedge clk);
        while (!pair.ready)
            @(posedge clk);
        hit_queue.push_back((want >= 0) ? bit'(want) : exp_hit);
        sent_count++;
    endtask

    // ---------------- result side ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got_count++;
                if (hit_queue.size() == 0)
                begin
                    report_mismatch("unexpected result", -1, result.hit);
                end
                else
                begin
                    if (result.hit !== hit_queue[0])
                        report_mismatch("hit", hit_queue[0], result.hit);
                    hit_count += hit_queue[0];
                    void'(hit_queue.pop_front());
                end
            end
            // stall now and then, in bursts
            if ($urandom_range(99) < 8)
                result.ready <= 1'b0;
            else if ($urandom_range(99) < 40)
                result.ready <= 1'b1;
        end
    end

    // watchdog on accepted words of either channel
    always @(posedge clk)
    begin
        if (!rst_n || (pair.valid && pair.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results pending", hit_queue.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial
    begin
        int drain;
        fail_count  = 0;
        sent_count  = 0;
        got_count   = 0;
        hit_count   = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        pair.valid  = 1'b0;
        pair.kind_a = KIND_CIRCLE;
        pair.a_x0 = '0; pair.a_y0 = '0; pair.a_x1 = '0; pair.a_y1 = '0;
        pair.kind_b = KIND_CIRCLE;
        pair.b_x0 = '0; pair.b_y0 = '0; pair.b_x1 = '0; pair.b_y1 = '0;

        // circle-circle: touching, apart, negative radius, extreme coordinates
        add_row(mk(KIND_CIRCLE, 0, 0, 5, 0, KIND_CIRCLE, 10, 0, 5, 0), 1);
        add_row(mk(KIND_CIRCLE, 0, 0, 5, 0, KIND_CIRCLE, 11, 0, 5, 0), 0);
        add_row(mk(KIND_CIRCLE, 0, 0, -5, 0, KIND_CIRCLE, 0, 0, -1, 0), 1);
        add_row(mk(KIND_CIRCLE, -32768, -32768, 32767, 32767,
                   KIND_CIRCLE, 32767, 32767, 32767, -32768), 0);
        add_row(mk(KIND_CIRCLE, -32768, -32768, 32767, 0,
                   KIND_CIRCLE, 0, 0, 32767, 0), 1);
        // rect-rect: touching edges, apart, negative size
        add_row(mk(KIND_RECT, 0, 0, 4, 4, KIND_RECT, 4, 0, 4, 4), 1);
        add_row(mk(KIND_RECT, 0, 0, 4, 4, KIND_RECT, 5, 0, 4, 4), 0);
        add_row(mk(KIND_RECT, 0, 0, -4, -4, KIND_RECT, 0, 0, -1, -1), 1);
        add_row(mk(KIND_RECT, -32768, -32768, 32767, 32767,
                   KIND_RECT, 32767, 32767, 32767, 32767), 0);
        // circle-rect: edge case, corner case, corner miss
        add_row(mk(KIND_CIRCLE, 6, 0, 3, 0, KIND_RECT, 0, 0, 8, 8), 1);
        add_row(mk(KIND_CIRCLE, 10, 10, 3, 0, KIND_RECT, 0, 0, 12, 12), -1);
        add_row(mk(KIND_RECT, 0, 0, 12, 12, KIND_CIRCLE, 9, 9, 4, 0), -1);
        // circle-segment: before start, past end, middle, zero length
        add_row(mk(KIND_CIRCLE, -3, 0, 3, 0, KIND_SEG, 0, 0, 10, 0), 1);
        add_row(mk(KIND_SEG, 0, 0, 10, 0, KIND_CIRCLE, 14, 0, 3, 0), 0);
        add_row(mk(KIND_CIRCLE, 5, 3, 3, 0, KIND_SEG, 0, 0, 10, 0), 1);
        add_row(mk(KIND_CIRCLE, 5, 5, 3, 0, KIND_SEG, 5, 2, 5, 2), 1);
        add_row(mk(KIND_CIRCLE, 32767, 32767, 32767, 0,
                   KIND_SEG, -32768, -32768, 32767, -32768), -1);
        // segment-segment: crossing, end-point touch, parallel, zero length
        add_row(mk(KIND_SEG, 0, 0, 10, 10, KIND_SEG, 0, 10, 10, 0), 1);
        add_row(mk(KIND_SEG, 0, 0, 10, 10, KIND_SEG, 10, 10, 20, 0), 0);
        add_row(mk(KIND_SEG, 0, 0, 10, 0, KIND_SEG, 0, 0, 10, 0), 0);
        add_row(mk(KIND_SEG, 3, 3, 3, 3, KIND_SEG, 0, 10, 10, 0), 0);
        add_row(mk(KIND_SEG, -32768, -32768, 32767, 32767,
                   KIND_SEG, -32768, 32767, 32767, -32768), 1);
        // rect-segment: crossing an edge, wholly inside
        add_row(mk(KIND_RECT, 0, 0, 5, 5, KIND_SEG, -10, 1, 10, 1), 1);
        add_row(mk(KIND_SEG, -1, -1, 1, 1, KIND_RECT, 0, 0, 5, 5), 0);
        // generic shape never hits
        add_row(mk(KIND_NONE, 0, 0, 5, 5, KIND_CIRCLE, 0, 0, 5, 0), 0);
        add_row(mk(KIND_RECT, 0, 0, 5, 5, KIND_NONE, 0, 0, 5, 5), 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
            send_pair(dir_table[i].p, dir_table[i].want);

        for (int n = 0; n < 700; n++)
        begin
            // hold off until the pipeline has drained once, midway
            if (n == 350)
            begin
                pair.valid <= 1'b0;
                while (hit_queue.size() != 0)
                    @(posedge clk);
            end
            // stretches without gaps fall out of the gap draw itself
            send_pair(rand_pair(), -1);
        end
        pair.valid <= 1'b0;

        while (hit_queue.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 20)
        begin
            @(posedge clk);
            drain++;
        end

        $display("Sent %0d shape pairs (%0d directed), checked %0d results, %0d hits.",
                 sent_count, dir_table.size(), got_count, hit_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
